/* sv/sfe_pkg.sv */
package sfe_pkg;

    // Only the low RADICAND_BITS bits of a radicand take part.
    localparam int RADICAND_BITS = 24;

    localparam int NUM_W   = 24;
    localparam int SQ_W    = 25;
    localparam int ODD_W   = 14;
    localparam int ROOT_W  = 13;
    localparam int OUTER_W = 14;
    localparam int DIV_CNT_W = 5;

    localparam logic [NUM_W-1:0] RAD_MASK =
        NUM_W'((SQ_W'(1) << RADICAND_BITS) - SQ_W'(1));

    // Outer factor that marks the inner value as the exact answer.
    localparam logic [OUTER_W-1:0] OUTER_EXACT = {OUTER_W{1'b1}};

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic [NUM_W-1:0] remainder;
    } div_result_t;

endpackage

/* sv/sfe_div.sv */
module sfe_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfe_pkg::NUM_W-1:0]   dividend,
    input  logic [sfe_pkg::NUM_W-1:0]   divisor,
    output sfe_pkg::div_result_t        result
);

    localparam logic [sfe_pkg::DIV_CNT_W-1:0] LAST_STEP =
        sfe_pkg::DIV_CNT_W'(sfe_pkg::NUM_W - 1);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [sfe_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [sfe_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic [sfe_pkg::NUM_W-1:0]       rem_reg;
    logic [sfe_pkg::NUM_W-1:0]       rem_next;
    logic [sfe_pkg::NUM_W-1:0]       quo_reg;
    logic [sfe_pkg::NUM_W-1:0]       quo_next;
    logic [sfe_pkg::NUM_W:0]         trial;
    logic [sfe_pkg::NUM_W:0]         diff;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[sfe_pkg::NUM_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[sfe_pkg::NUM_W])
            begin
                rem_next = diff[sfe_pkg::NUM_W-1:0];
                quo_next = {quo_reg[sfe_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[sfe_pkg::NUM_W-1:0];
                quo_next = {quo_reg[sfe_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

/* sv/square_factor_extractor.sv */
// A radicand of 0 or 1 goes from S_IDLE to S_FINAL, and S_FINAL loads its result into the output register.
// Otherwise a walk over k with odd increments to k*k finds the root; a non-square n then
// scans every k with k*k < n, each by a 24-step division of n by k*k in S_DIV.
// A new radicand is taken only in S_IDLE, once the block is through with the one before.
// Reset: asynchronous, active low, clears all control state at once; no clearing pass.
module square_factor_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // radicand[23:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // outer_factor[13:0], inner_value[37:14], zero pad
    output logic        m_axis_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROOT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;

    localparam logic [sfe_pkg::ROOT_W-1:0] K_START   = sfe_pkg::ROOT_W'(2);
    localparam logic [sfe_pkg::SQ_W-1:0]   SQ_START  = sfe_pkg::SQ_W'(4);
    localparam logic [sfe_pkg::ODD_W-1:0]  ODD_START = sfe_pkg::ODD_W'(5);

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [sfe_pkg::NUM_W-1:0]         n_reg;
    logic [sfe_pkg::NUM_W-1:0]         n_next;
    logic [sfe_pkg::ROOT_W-1:0]        k_reg;
    logic [sfe_pkg::ROOT_W-1:0]        k_next;
    logic [sfe_pkg::SQ_W-1:0]          sq_reg;
    logic [sfe_pkg::SQ_W-1:0]          sq_next;
    logic [sfe_pkg::ODD_W-1:0]         odd_reg;
    logic [sfe_pkg::ODD_W-1:0]         odd_next;
    logic                              pend_valid_reg;
    logic                              pend_valid_next;
    logic [sfe_pkg::OUTER_W-1:0]       pend_outer_reg;
    logic [sfe_pkg::OUTER_W-1:0]       pend_outer_next;
    logic [sfe_pkg::NUM_W-1:0]         pend_inner_reg;
    logic [sfe_pkg::NUM_W-1:0]         pend_inner_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [sfe_pkg::OUTER_W-1:0]       out_outer_reg;
    logic [sfe_pkg::OUTER_W-1:0]       out_outer_next;
    logic [sfe_pkg::NUM_W-1:0]         out_inner_reg;
    logic [sfe_pkg::NUM_W-1:0]         out_inner_next;
    logic                              out_last_reg;
    logic                              out_last_next;

    logic                              out_free;
    logic                              out_load;
    logic                              sq_below;
    logic                              div_start;
    logic [sfe_pkg::NUM_W-1:0]         n_in;
    sfe_pkg::div_result_t              div_res;

    sfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (sq_reg[sfe_pkg::NUM_W-1:0]),
        .result   (div_res)
    );

    assign n_in      = s_axis_tdata & sfe_pkg::RAD_MASK;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign sq_below  = sq_reg < {1'b0, n_reg};
    assign div_start = (state_reg == S_SCAN) && sq_below;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        sq_next         = sq_reg;
        odd_next        = odd_reg;
        pend_valid_next = pend_valid_reg;
        pend_outer_next = pend_outer_reg;
        pend_inner_next = pend_inner_reg;
        out_load        = 1'b0;
        out_outer_next  = out_outer_reg;
        out_inner_next  = out_inner_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                k_next   = K_START;
                sq_next  = SQ_START;
                odd_next = ODD_START;
                if (s_axis_tvalid)
                begin
                    n_next = n_in;
                    if (n_in <= sfe_pkg::NUM_W'(1))
                    begin
                        pend_valid_next = 1'b1;
                        pend_outer_next = sfe_pkg::OUTER_EXACT;
                        pend_inner_next = n_in;
                        state_next      = S_FINAL;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = S_ROOT;
                    end
                end
            end
            S_ROOT:
            begin
                if (sq_below)
                begin
                    sq_next  = sq_reg + sfe_pkg::SQ_W'(odd_reg);
                    odd_next = odd_reg + sfe_pkg::ODD_W'(2);
                    k_next   = k_reg + 1'b1;
                end
                else if (sq_reg == {1'b0, n_reg})
                begin
                    pend_valid_next = 1'b1;
                    pend_outer_next = sfe_pkg::OUTER_EXACT;
                    pend_inner_next = sfe_pkg::NUM_W'(k_reg);
                    state_next      = S_FINAL;
                end
                else
                begin
                    k_next     = K_START;
                    sq_next    = SQ_START;
                    odd_next   = ODD_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = sq_below ? S_DIV : S_FINAL;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (div_res.remainder == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sq_next    = sq_reg + sfe_pkg::SQ_W'(odd_reg);
                        odd_next   = odd_reg + sfe_pkg::ODD_W'(2);
                        k_next     = k_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_EMIT:
            begin
                // A new hit pushes the held one out, which then is known not to be last.
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load       = 1'b1;
                        out_outer_next = pend_outer_reg;
                        out_inner_next = pend_inner_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_outer_next = sfe_pkg::OUTER_W'(k_reg);
                    pend_inner_next = div_res.quotient;
                    sq_next         = sq_reg + sfe_pkg::SQ_W'(odd_reg);
                    odd_next        = odd_reg + sfe_pkg::ODD_W'(2);
                    k_next          = k_reg + 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_FINAL:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_outer_next  = pend_outer_reg;
                    out_inner_next  = pend_inner_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        sq_reg         <= sq_next;
        odd_reg        <= odd_next;
        pend_outer_reg <= pend_outer_next;
        pend_inner_reg <= pend_inner_next;
        out_outer_reg  <= out_outer_next;
        out_inner_reg  <= out_inner_next;
        out_last_reg   <= out_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_inner_reg, out_outer_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

/* sim/tb_square_factor_extractor.sv */
module tb_square_factor_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FACTORS  = 48;
    localparam int RANDOM_ITEMS = 82;
    localparam int IDLE_LIMIT   = 500000;

    typedef struct packed {
        logic [sfe_pkg::OUTER_W-1:0] outer_factor;
        logic [sfe_pkg::NUM_W-1:0]   inner_value;
        logic                        last;
    } factor_result_t;

    class factor_scoreboard;
        factor_result_t expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Walks k from 2 with k squared built from odd increments, the same way the
        // block does, and queues each (k, n / k^2), up to MAX_FACTORS of them, or the exact root.
        function void note_radicand(logic [sfe_pkg::NUM_W-1:0] radicand);
            int unsigned n;
            int unsigned k;
            int unsigned sq;
            int unsigned odd;
            factor_result_t found[$];
            factor_result_t item;

            n = int'(radicand & sfe_pkg::RAD_MASK);
            if (n <= 1) begin
                item.outer_factor = sfe_pkg::OUTER_EXACT;
                item.inner_value  = sfe_pkg::NUM_W'(n);
                item.last         = 1'b1;
                expected_q = {expected_q, item};
                return;
            end
            k   = 2;
            sq  = 4;
            odd = 5;
            while (sq < n) begin
                if (n % sq == 0 && found.size() < MAX_FACTORS) begin
                    item.outer_factor = sfe_pkg::OUTER_W'(k);
                    item.inner_value  = sfe_pkg::NUM_W'(n / sq);
                    item.last         = 1'b0;
                    found = {found, item};
                end
                sq  += odd;
                odd += 2;
                k   += 1;
            end
            if (sq == n) begin
                item.outer_factor = sfe_pkg::OUTER_EXACT;
                item.inner_value  = sfe_pkg::NUM_W'(k);
                item.last         = 1'b1;
                expected_q = {expected_q, item};
                return;
            end
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            expected_q = {expected_q, found};
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [39:0] tdata, logic tlast);
            factor_result_t exp_item;

            if (expected_q.size() == 0) begin
                $error("result with nothing pending: outer_factor %0d inner_value %0d",
                       $signed(tdata[13:0]), tdata[37:14]);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            compare_field("outer_factor", int'($signed(exp_item.outer_factor)),
                          int'($signed(tdata[13:0])));
            compare_field("inner_value", int'(exp_item.inner_value), int'(tdata[37:14]));
            compare_field("last", int'(exp_item.last), int'(tlast));
            compare_field("pad", 0, int'(tdata[39:38]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    factor_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;
    int big_left = 2;

    square_factor_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5ns clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(20, 80);
    endfunction

    // Most values stay small because a non-square costs a full division for each
    // candidate k; perfect squares are cheap and reach the top bits.
    function automatic logic [sfe_pkg::NUM_W-1:0] random_radicand();
        int unsigned r;
        int unsigned k;
        int unsigned m;
        int unsigned root;

        r = $urandom_range(0, 99);
        if (r < 35)
            return sfe_pkg::NUM_W'($urandom_range(0, 4095));
        if (r < 65) begin
            k = $urandom_range(2, 40);
            m = $urandom_range(1, 65535 / (k * k));
            return sfe_pkg::NUM_W'(k * k * m);
        end
        if (r < 85) begin
            root = $urandom_range(0, 4095);
            return sfe_pkg::NUM_W'(root * root);
        end
        if (r < 97 || big_left == 0)
            return sfe_pkg::NUM_W'($urandom_range(0, 65535));
        big_left--;
        return sfe_pkg::NUM_W'($urandom) & sfe_pkg::RAD_MASK;
    endfunction

    task automatic send_radicand(input logic [sfe_pkg::NUM_W-1:0] radicand);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= radicand;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_radicand(radicand);
    endtask

    // The receiver stalls at random, with occasional calm stretches of full readiness.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else begin
            m_axis_tready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                if ($urandom_range(0, 7) == 0)
                    calm_left = $urandom_range(50, 300);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [sfe_pkg::NUM_W-1:0] directed[$];
        int i;

        // Zero and one, small square-free values, perfect squares, values with
        // several square divisors, the largest square and the all-ones value.
        directed = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd8, 24'd9, 24'd12,
                     24'd16, 24'd48, 24'd72, 24'd4096, 24'd9216, 24'd50400,
                     24'd16769025, 24'h800000, 24'hFFFFFF};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[j])
            send_radicand(directed[j]);
        for (i = 0; i < RANDOM_ITEMS; i++)
            send_radicand(random_radicand());
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        // A square-free radicand keeps the block scanning without any output.
        while (!s_axis_tready)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
sv/sfe_pkg.sv
sv/sfe_div.sv
sv/square_factor_extractor.sv
sim/tb_square_factor_extractor.sv
